>>> rtl/gbd_pkg.sv
`default_nettype none
package gbd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register field widths
    localparam int FRAME_W = 11;
    localparam int OUT_W_W = 9;

    // vertical geometry is fixed by the height limit
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = 10;
    localparam int NBY_W        = 11;

    // register reset values
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic [OUT_W_W-1:0] OUT_WIDTH_RST    = 9'd160;
    localparam logic [FRAME_W-1:0] OUT_HEIGHT_RST   = 11'd120;

    // (r+g+b)/3 as a multiply by 683 and a shift by 11, exact below 2048
    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_OUT_WIDTH    = 2'd2,
        REG_OUT_HEIGHT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic restart;
        logic geom_ok;
    } pipe_ctl_t;

endpackage
`default_nettype wire

>>> rtl/gbd_div.sv
`default_nettype none
module gbd_div #(
    parameter int DV_W = 25,
    parameter int DS_W = 11
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [DV_W-1:0] dividend,
    input  wire logic [DS_W-1:0] divisor,
    output logic      [DV_W-1:0] quotient,
    output logic                 done
);

    localparam int CNT_W = $clog2(DV_W + 1);

    logic [DS_W-1:0]  rem_reg;
    logic [DV_W-1:0]  quo_reg;
    logic [DS_W-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DS_W:0]    trial;
    logic [DS_W:0]    diff;
    logic             ge;

    // one restoring step per cycle, msb first
    always_comb begin
        trial = {rem_reg, quo_reg[DV_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DS_W-1:0] : trial[DS_W-1:0];
            quo_reg <= {quo_reg[DV_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

>>> rtl/gbd_setup.sv
`default_nettype none
module gbd_setup
    import gbd_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 1024,
    parameter int MAX_OUT_WIDTH   = 256,
    parameter int MAX_RATIO       = 16,
    localparam int RATIO_W = $clog2(MAX_RATIO + 1),
    localparam int NBX_W   = $clog2(MAX_OUT_WIDTH + 1),
    localparam int SUM_W   = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1),
    localparam int SH_K    = SUM_W + $clog2(MAX_RATIO * MAX_RATIO),
    localparam int RCP_W   = SH_K + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output pipe_ctl_t                  ctl,
    output logic      [FRAME_W-1:0]    fw_c,
    output logic      [FRAME_W-1:0]    fh_c,
    output logic      [RATIO_W-1:0]    rx,
    output logic      [RATIO_W-1:0]    ry,
    output logic      [NBX_W-1:0]      nbx,
    output logic      [NBY_W-1:0]      nby,
    output logic      [RCP_W-1:0]      recip
);

    localparam int AREA_W = $clog2(MAX_RATIO * MAX_RATIO + 1);
    localparam int DV_W   = (RCP_W > FRAME_W) ? RCP_W : FRAME_W;
    localparam int DS_W   = (AREA_W > FRAME_W) ? AREA_W : FRAME_W;

    typedef enum logic [2:0] {
        S_RX,
        S_RY,
        S_NBX,
        S_NBY,
        S_AREA,
        S_RECIP,
        S_DONE
    } state_t;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;
    logic [OUT_W_W-1:0] out_width_reg;
    logic [FRAME_W-1:0] out_height_reg;

    state_t             state_reg;
    logic               issued_reg;
    logic               div_start_reg;
    logic [RATIO_W-1:0] rx_reg;
    logic [RATIO_W-1:0] ry_reg;
    logic [NBX_W-1:0]   nbx_reg;
    logic [NBY_W-1:0]   nby_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [RCP_W-1:0]   recip_reg;

    logic [DV_W-1:0]    div_num;
    logic [DS_W-1:0]    div_den;
    logic [DV_W-1:0]    div_quo;
    logic               div_done;
    logic               is_div;
    logic               captured;

    function automatic logic [RATIO_W-1:0] clamp_ratio(input logic [DV_W-1:0] q,
                                                       input logic zero_out);
        logic [RATIO_W-1:0] r;
        if (zero_out || q > DV_W'(MAX_RATIO)) begin
            r = RATIO_W'(MAX_RATIO);
        end else if (q == '0) begin
            r = RATIO_W'(1);
        end else begin
            r = q[RATIO_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            out_width_reg    <= OUT_WIDTH_RST;
            out_height_reg   <= OUT_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_W-1:0];
                REG_OUT_WIDTH:    out_width_reg    <= cfg_data[OUT_W_W-1:0];
                REG_OUT_HEIGHT:   out_height_reg   <= cfg_data[FRAME_W-1:0];
            endcase
        end
    end

    always_comb begin
        fw_c = frame_width_reg;
        if (frame_width_reg == '0) begin
            fw_c = FRAME_W'(1);
        end else if (32'(frame_width_reg) > MAX_FRAME_WIDTH) begin
            fw_c = FRAME_W'(MAX_FRAME_WIDTH);
        end
        fh_c = frame_height_reg;
        if (frame_height_reg == '0) begin
            fh_c = FRAME_W'(1);
        end else if (32'(frame_height_reg) > HEIGHT_LIMIT) begin
            fh_c = FRAME_W'(HEIGHT_LIMIT);
        end
    end

    // operands of the shared divider follow the sequencer step
    always_comb begin
        div_num = '0;
        div_den = '0;
        case (state_reg)
            S_RX: begin
                div_num = DV_W'(fw_c);
                div_den = DS_W'(out_width_reg);
            end
            S_RY: begin
                div_num = DV_W'(fh_c);
                div_den = DS_W'(out_height_reg);
            end
            S_NBX: begin
                div_num = DV_W'(fw_c);
                div_den = DS_W'(rx_reg);
            end
            S_NBY: begin
                div_num = DV_W'(fh_c);
                div_den = DS_W'(ry_reg);
            end
            S_RECIP: begin
                // ceiling of 2^k over the block area
                div_num = (DV_W'(1) << SH_K) + DV_W'(area_reg) - DV_W'(1);
                div_den = DS_W'(area_reg);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
        is_div   = (state_reg != S_AREA) && (state_reg != S_DONE);
        // a done that lines up with a fresh start belongs to an aborted run
        captured = issued_reg && div_done && !div_start_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            state_reg     <= S_RX;
            issued_reg    <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= is_div && !issued_reg;
            if (is_div && !issued_reg) begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                S_RX: begin
                    if (captured) begin
                        rx_reg     <= clamp_ratio(div_quo, out_width_reg == '0);
                        issued_reg <= 1'b0;
                        state_reg  <= S_RY;
                    end
                end
                S_RY: begin
                    if (captured) begin
                        ry_reg     <= clamp_ratio(div_quo, out_height_reg == '0);
                        issued_reg <= 1'b0;
                        state_reg  <= S_NBX;
                    end
                end
                S_NBX: begin
                    if (captured) begin
                        nbx_reg    <= (div_quo > DV_W'(MAX_OUT_WIDTH)) ?
                                      NBX_W'(MAX_OUT_WIDTH) : div_quo[NBX_W-1:0];
                        issued_reg <= 1'b0;
                        state_reg  <= S_NBY;
                    end
                end
                S_NBY: begin
                    if (captured) begin
                        nby_reg    <= div_quo[NBY_W-1:0];
                        issued_reg <= 1'b0;
                        state_reg  <= S_AREA;
                    end
                end
                S_AREA: begin
                    area_reg  <= AREA_W'(AREA_W'(rx_reg) * AREA_W'(ry_reg));
                    state_reg <= S_RECIP;
                end
                S_RECIP: begin
                    if (captured) begin
                        recip_reg  <= div_quo[RCP_W-1:0];
                        issued_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE: begin
                    state_reg <= S_DONE;
                end
                default: begin
                    state_reg <= S_RX;
                end
            endcase
        end
    end

    gbd_div #(
        .DV_W(DV_W),
        .DS_W(DS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .dividend(div_num),
        .divisor (div_den),
        .quotient(div_quo),
        .done    (div_done)
    );

    assign ctl.restart = cfg_we;
    assign ctl.geom_ok = (state_reg == S_DONE);
    assign rx          = rx_reg;
    assign ry          = ry_reg;
    assign nbx         = nbx_reg;
    assign nby         = nby_reg;
    assign recip       = recip_reg;

endmodule
`default_nettype wire

>>> rtl/gbd_accum.sv
`default_nettype none
module gbd_accum
    import gbd_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 1024,
    parameter int MAX_OUT_WIDTH   = 256,
    parameter int MAX_RATIO       = 16,
    localparam int RATIO_W = $clog2(MAX_RATIO + 1),
    localparam int NBX_W   = $clog2(MAX_OUT_WIDTH + 1),
    localparam int SUM_W   = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1),
    localparam int SH_K    = SUM_W + $clog2(MAX_RATIO * MAX_RATIO),
    localparam int RCP_W   = SH_K + 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pipe_ctl_t          ctl,
    input  wire logic [FRAME_W-1:0] fw_c,
    input  wire logic [FRAME_W-1:0] fh_c,
    input  wire logic [RATIO_W-1:0] rx,
    input  wire logic [RATIO_W-1:0] ry,
    input  wire logic [NBX_W-1:0]   nbx,
    input  wire logic [NBY_W-1:0]   nby,
    input  wire logic [RCP_W-1:0]   recip,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_red,
    input  wire logic [7:0]         s_green,
    input  wire logic [7:0]         s_blue,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [7:0]         m_gray,
    output logic                    m_frame_done
);

    localparam int SUB_W  = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
    localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int CC_W   = $clog2(MAX_FRAME_WIDTH);
    localparam int COL_W  = (CC_W + 1 > FRAME_W) ? CC_W + 1 : FRAME_W;
    localparam int PROD_W = SUM_W + RCP_W;

    // position in the frame
    logic [CC_W-1:0]    col_reg,       col_next;
    logic [ROW_W-1:0]   row_reg,       row_next;
    logic [SUB_W-1:0]   sub_col_reg,   sub_col_next;
    logic [SUB_W-1:0]   sub_row_reg,   sub_row_next;
    logic [NBX_W-1:0]   block_col_reg, block_col_next;
    logic [NBY_W-1:0]   block_row_reg, block_row_next;

    // block sum store
    logic [SUM_W-1:0]   sum_mem [MAX_OUT_WIDTH];
    logic [MAX_OUT_WIDTH-1:0] vld_reg;
    logic [SUM_W-1:0]   rd_data_reg;
    logic               rd_vld_reg;

    // stage 1: read-modify-write
    logic               s1_valid_reg;
    logic               s1_keep_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [7:0]         s1_gray_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    // last write, for a read that raced it
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [SUM_W-1:0]   fwd_data_reg;

    // stage 2: divide by area through the reciprocal
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [SUM_W-1:0]   s2_sum_reg;

    logic               m_valid_reg;
    logic [7:0]         m_gray_reg;
    logic               m_frame_done_reg;

    logic               adv;
    logic               accept;
    logic [9:0]         rgb_sum;
    logic [19:0]        gray_prod;
    logic [7:0]         gray0;
    logic               keep;
    logic               emit;
    logic               last;
    logic [RATIO_W-1:0] sc_inc;
    logic [RATIO_W-1:0] sr_inc;
    logic [COL_W-1:0]   cc_inc;
    logic [FRAME_W-1:0] rr_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   sum1;
    logic               wr_en;
    logic [SUM_W-1:0]   wr_data;
    logic [PROD_W-1:0]  avg_prod;

    // the whole pipe holds while a finished word waits at the output
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = ctl.geom_ok && adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        rgb_sum   = 10'(s_red) + 10'(s_green) + 10'(s_blue);
        gray_prod = 20'(rgb_sum) * 20'(GRAY_RECIP);
        gray0     = gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];

        sc_inc = RATIO_W'(sub_col_reg) + RATIO_W'(1);
        sr_inc = RATIO_W'(sub_row_reg) + RATIO_W'(1);
        cc_inc = COL_W'(col_reg) + COL_W'(1);
        rr_inc = FRAME_W'(row_reg) + FRAME_W'(1);

        // pixels right of the last whole block or below the last whole row drop out
        keep = (block_col_reg < nbx) && (block_row_reg < nby);
        emit = keep && (sc_inc == rx) && (sr_inc == ry);
        last = (block_col_reg == nbx - NBX_W'(1)) && (block_row_reg == nby - NBY_W'(1));

        rd_addr = block_col_reg[ADDR_W-1:0];

        col_next       = col_reg;
        row_next       = row_reg;
        sub_col_next   = sub_col_reg;
        sub_row_next   = sub_row_reg;
        block_col_next = block_col_reg;
        block_row_next = block_row_reg;
        if (accept) begin
            if (keep) begin
                if (sc_inc == rx) begin
                    sub_col_next   = '0;
                    block_col_next = block_col_reg + NBX_W'(1);
                end else begin
                    sub_col_next = sub_col_reg + SUB_W'(1);
                end
            end
            if (cc_inc >= COL_W'(fw_c)) begin
                col_next       = '0;
                sub_col_next   = '0;
                block_col_next = '0;
                if (sr_inc >= ry) begin
                    sub_row_next   = '0;
                    block_row_next = block_row_reg + NBY_W'(1);
                end else begin
                    sub_row_next = sub_row_reg + SUB_W'(1);
                end
                if (rr_inc >= fh_c) begin
                    row_next       = '0;
                    sub_row_next   = '0;
                    block_row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + CC_W'(1);
            end
        end
    end

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            base = fwd_data_reg;
        end else if (rd_vld_reg) begin
            base = rd_data_reg;
        end else begin
            base = '0;
        end
        sum1     = base + SUM_W'(s1_gray_reg);
        wr_en    = adv && s1_valid_reg && s1_keep_reg;
        wr_data  = s1_emit_reg ? '0 : sum1;
        avg_prod = PROD_W'(s2_sum_reg) * PROD_W'(recip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            col_reg       <= '0;
            row_reg       <= '0;
            sub_col_reg   <= '0;
            sub_row_reg   <= '0;
            block_col_reg <= '0;
            block_row_reg <= '0;
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            sub_col_reg   <= sub_col_next;
            sub_row_reg   <= sub_row_next;
            block_col_reg <= block_col_next;
            block_row_reg <= block_row_next;
            if (wr_en) begin
                vld_reg[s1_addr_reg] <= 1'b1;
            end
            if (adv) begin
                s1_valid_reg  <= accept;
                fwd_valid_reg <= wr_en;
                s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= sum_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            s1_keep_reg <= keep;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_gray_reg <= gray0;
            s1_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sum_mem[s1_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fwd_addr_reg     <= s1_addr_reg;
            fwd_data_reg     <= wr_data;
            s2_sum_reg       <= sum1;
            s2_last_reg      <= s1_last_reg;
            m_gray_reg       <= avg_prod[SH_K+7:SH_K];
            m_frame_done_reg <= s2_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_gray       = m_gray_reg;
    assign m_frame_done = m_frame_done_reg;

endmodule
`default_nettype wire

>>> rtl/gray_box_downscaler.sv
`default_nettype none
// Grayscale box downscaler: takes one RGB pixel per clock in raster order, turns it to
// gray as (r+g+b)/3 and averages ratio_x by ratio_y blocks into one gray output word,
// flagging the last word of the frame. Pixels of partial edge blocks are dropped. After
// reset and after any register write the block works out the ratios, block counts and
// a reciprocal of the block area on one shared bit-serial divider, 25 bits wide at the
// default parameters, and s_ready stays low meanwhile. After that one pixel is taken
// every cycle while no result waits at the output; the rate is set by the block-sum
// memory, which reads a column sum and writes it back from the stage 1 registers, with
// forwarding when neighboring pixels hit the same column. The pixel that completes a
// block passes through the stage 1, stage 2 and output registers before its result
// appears, and the whole pipeline holds while a result waits at the output.
module gray_box_downscaler
    import gbd_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 1024,
    parameter int MAX_OUT_WIDTH   = 256,
    parameter int MAX_RATIO       = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_red,
    input  wire logic [7:0]            s_green,
    input  wire logic [7:0]            s_blue,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [7:0]            m_gray,
    output logic                       m_frame_done
);

    localparam int RATIO_W = $clog2(MAX_RATIO + 1);
    localparam int NBX_W   = $clog2(MAX_OUT_WIDTH + 1);
    localparam int SUM_W   = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1);
    localparam int SH_K    = SUM_W + $clog2(MAX_RATIO * MAX_RATIO);
    localparam int RCP_W   = SH_K + 1;

    pipe_ctl_t          ctl;
    logic [FRAME_W-1:0] fw_c;
    logic [FRAME_W-1:0] fh_c;
    logic [RATIO_W-1:0] rx;
    logic [RATIO_W-1:0] ry;
    logic [NBX_W-1:0]   nbx;
    logic [NBY_W-1:0]   nby;
    logic [RCP_W-1:0]   recip;

    gbd_setup #(
        .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH),
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_RATIO      (MAX_RATIO)
    ) u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data),
        .ctl     (ctl),
        .fw_c    (fw_c),
        .fh_c    (fh_c),
        .rx      (rx),
        .ry      (ry),
        .nbx     (nbx),
        .nby     (nby),
        .recip   (recip)
    );

    gbd_accum #(
        .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH),
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_RATIO      (MAX_RATIO)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .fw_c        (fw_c),
        .fh_c        (fh_c),
        .rx          (rx),
        .ry          (ry),
        .nbx         (nbx),
        .nby         (nby),
        .recip       (recip),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_gray      (m_gray),
        .m_frame_done(m_frame_done)
    );

endmodule
`default_nettype wire

>>> rtl/gbd_checker.sv
`default_nettype none
module gbd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       cfg_we,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_gray,
    input wire logic       m_frame_done
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gray) && $stable(m_frame_done))
        else $error("result word changed or dropped while stalled");

    // a register write restarts the setup, so no pixel is taken right after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("pixel input ready right after a register write");

    // reset leaves nothing to deliver and nothing taken
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output valid or input ready right after reset");

    // no pixel can be taken while the setup of a fresh write is still running
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we ##1 !cfg_we |=> !(s_valid && s_ready))
        else $error("pixel taken before setup finished");

endmodule

bind gray_box_downscaler gbd_checker u_gbd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_we      (cfg_we),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_gray      (m_gray),
    .m_frame_done(m_frame_done)
);
`default_nettype wire

>>> tb/gray_box_downscaler_tb.sv
`timescale 1ns / 1ps

module gray_box_downscaler_tb;
    import gbd_pkg::*;

    localparam int MAX_FRAME_WIDTH = 1024;
    localparam int MAX_OUT_WIDTH   = 256;
    localparam int MAX_RATIO       = 16;

    typedef struct packed {
        logic [7:0] gray;
        logic       frame_done;
    } gray_word_t;

    // tracks the downscaler geometry and block sums, holds the words still due
    class block_avg_board;
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
        logic [OUT_W_W-1:0] out_w;
        logic [FRAME_W-1:0] out_h;
        logic [15:0]        col_sums [MAX_OUT_WIDTH];
        int unsigned        col_pos, row_pos, blk_x, blk_y, blk_col;
        gray_word_t         due_words [$];
        int                 mismatches;
        int                 words_seen;

        function new();
            frame_w    = FRAME_WIDTH_RST;
            frame_h    = FRAME_HEIGHT_RST;
            out_w      = OUT_WIDTH_RST;
            out_h      = OUT_HEIGHT_RST;
            mismatches = 0;
            words_seen = 0;
            restart();
        endfunction

        function void restart();
            foreach (col_sums[i]) col_sums[i] = '0;
            col_pos = 0;
            row_pos = 0;
            blk_x   = 0;
            blk_y   = 0;
            blk_col = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:  frame_w = val;
                REG_FRAME_HEIGHT: frame_h = val;
                REG_OUT_WIDTH:    out_w   = val[OUT_W_W-1:0];
                REG_OUT_HEIGHT:   out_h   = val;
                default:          return;
            endcase
            restart();
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned block_ratio(int unsigned size, int unsigned outsz);
            if (outsz == 0) return MAX_RATIO;
            return clamp(size / outsz, 1, MAX_RATIO);
        endfunction

        function void add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned fw, fh, rx, ry, nbx, nby;
            logic [9:0]  rgb_sum;
            logic [7:0]  gray;
            gray_word_t  w;
            fw      = clamp(frame_w, 1, MAX_FRAME_WIDTH);
            fh      = clamp(frame_h, 1, HEIGHT_LIMIT);
            rx      = block_ratio(fw, out_w);
            ry      = block_ratio(fh, out_h);
            nbx     = fw / rx;
            nby     = fh / ry;
            rgb_sum = r + g + b;
            gray    = rgb_sum / 3;
            if (nbx > MAX_OUT_WIDTH) nbx = MAX_OUT_WIDTH;

            // pixels of partial edge blocks never reach a sum
            if (nbx > 0 && nby > 0 && col_pos < nbx * rx && row_pos < nby * ry
                    && blk_col < MAX_OUT_WIDTH) begin
                col_sums[blk_col] += gray;
                if (blk_x == rx - 1 && blk_y == ry - 1) begin
                    w.gray       = col_sums[blk_col] / (rx * ry);
                    w.frame_done = (blk_col == nbx - 1) && (row_pos >= (nby - 1) * ry);
                    due_words.push_back(w);
                    col_sums[blk_col] = '0;
                end
                blk_x++;
                if (blk_x >= rx) begin
                    blk_x = 0;
                    blk_col++;
                end
            end

            col_pos++;
            if (col_pos >= fw) begin
                col_pos = 0;
                blk_x   = 0;
                blk_col = 0;
                blk_y++;
                if (blk_y >= ry) blk_y = 0;
                row_pos++;
                if (row_pos >= fh) begin
                    row_pos = 0;
                    blk_y   = 0;
                end
            end
        endfunction

        function void check_word(logic [7:0] gray, logic done);
            gray_word_t want;
            words_seen++;
            if (due_words.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: gray %0d frame_done %0b", gray, done);
                mismatches++;
                return;
            end
            want = due_words.pop_front();
            if (want.gray !== gray || want.frame_done !== done) begin
                if (mismatches < 10)
                    $display("word %0d: gray exp %0d got %0d, frame_done exp %0b got %0b",
                             words_seen, want.gray, gray, want.frame_done, done);
                mismatches++;
            end
        endfunction

        function int leftover();
            return due_words.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_red;
    logic [7:0]            s_green;
    logic [7:0]            s_blue;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_gray;
    logic                  m_frame_done;

    block_avg_board board;
    int             pixels_sent;
    int             src_mode;
    int             sink_mode;

    gray_box_downscaler #(
        .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH),
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_RATIO      (MAX_RATIO)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_gray      (m_gray),
        .m_frame_done(m_frame_done)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // 0: no idling, 1: occasional gaps, 2: a random gap drawn for every word
    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
            default: return $urandom_range(0, 10);
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_frame_extreme();
        case ($urandom_range(0, 6))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1023;
            3:       return 11'd1024;
            4:       return 11'd1025;
            5:       return 11'd2047;
            default: return 11'($urandom_range(2, 1022));
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        board.write_reg(idx, val);
    endtask

    // out_width only keeps nine bits, the upper data bits get random junk
    task automatic apply_geometry(input int fw, input int fh, input int ow, input int oh);
        logic [CFG_DATA_W-1:0] ow_data;
        ow_data = {2'($urandom_range(0, 3)), 9'(ow)};
        write_reg(REG_FRAME_WIDTH, 11'(fw));
        write_reg(REG_FRAME_HEIGHT, 11'(fh));
        write_reg(REG_OUT_WIDTH, ow_data);
        write_reg(REG_OUT_HEIGHT, 11'(oh));
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = draw_wait(src_mode);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_red   = r;
        s_green = g;
        s_blue  = b;
        do @(posedge aclk); while (!s_ready);
        board.add_pixel(r, g, b);
        pixels_sent++;
    endtask

    task automatic push_random(input int n);
        repeat (n) push_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    // drop valid, wait for every due word, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.leftover() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_phase();
        int fw, fh, ow, oh, area, n;
        src_mode  = $urandom_range(0, 2);
        sink_mode = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1: begin
                fw = pick_frame_extreme();
                fh = pick_frame_extreme();
                case ($urandom_range(0, 5))
                    0:       ow = 0;
                    1:       ow = 1;
                    2:       ow = 256;
                    3:       ow = 257;
                    4:       ow = 511;
                    default: ow = $urandom_range(2, 510);
                endcase
                oh = ($urandom_range(0, 2) == 0) ? pick_frame_extreme() : $urandom_range(0, 4);
                n  = $urandom_range(20, 60);
            end
            2, 3, 4: begin
                fw   = $urandom_range(1, 6);
                fh   = $urandom_range(1, 40);
                ow   = $urandom_range(0, fw);
                oh   = $urandom_range(0, fh);
                area = fw * fh;
                n    = area + $urandom_range(0, area);
            end
            default: begin
                fw   = $urandom_range(1, 24);
                fh   = $urandom_range(1, 6);
                ow   = $urandom_range(0, fw);
                oh   = $urandom_range(0, fh);
                area = fw * fh;
                n    = area + $urandom_range(0, area);
            end
        endcase
        if (n > 150) n = 150;
        apply_geometry(fw, fh, ow, oh);
        push_random(n);
        settle();
    endtask

    // result side
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = draw_wait(sink_mode);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
            board.check_word(m_gray, m_frame_done);
        end
    end

    initial begin
        #5_000_000;
        $display("gray_box_downscaler verification failed");
        $finish;
    end

    initial begin
        cfg_we      = 1'b0;
        cfg_idx     = REG_FRAME_WIDTH;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_red       = '0;
        s_green     = '0;
        s_blue      = '0;
        aresetn     = 1'b0;
        pixels_sent = 0;
        src_mode    = 0;
        sink_mode   = 0;
        board       = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset geometry 640x480 in 4x4 blocks: a few pixels give no word
        push_random(4);
        settle();

        // 2x2 blocks on a 4x2 frame, extremes of the channels
        sink_mode = 1;
        apply_geometry(4, 2, 2, 1);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd254);
        settle();

        // zero out_width falls back to the widest ratio
        src_mode = 2;
        apply_geometry(16, 1, 0, 1);
        push_random(16);
        settle();

        // more block columns than the sum store holds
        src_mode  = 1;
        sink_mode = 2;
        apply_geometry(260, 1, 300, 1);
        push_random(270);
        settle();

        while (pixels_sent < 750)
            random_phase();

        if (board.mismatches == 0 && board.leftover() == 0) begin
            $display("gray_box_downscaler verification clean");
        end else begin
            if (board.leftover() != 0)
                $display("%0d expected words never arrived", board.leftover());
            $display("gray_box_downscaler verification failed");
        end
        $finish;
    end

endmodule
